// ===== sv/ppn_pkg.sv =====
// ppn_pkg: shared widths, command codes and controller/datapath structs
// for the polygon plane (newell) block; no dependencies
package ppn_pkg;

  localparam int COORD_W = 24;
  localparam int NORM_W = 58;
  localparam int DIST_W = 64;
  localparam int CSUM_W = 32;
  localparam int MUL_W = 32;
  localparam int PROD_W = 64;
  localparam int WACC_W = 84;
  localparam int SS_W = 64;
  localparam int ROOT_W = 31;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 31;
  localparam int UNIT_W = 16;
  localparam int FRAC_W = 14;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF = 24;

  typedef enum logic [2:0] {
    MUL_NEWELL,
    MUL_FAST_LO,
    MUL_FAST_HI,
    MUL_SQUARE,
    MUL_DOT
  } mul_e;

  typedef enum logic [1:0] {
    RES_DEGEN,
    RES_FAST,
    RES_ACC
  } res_e;

  typedef enum logic {
    DIV_UNIT,
    DIV_DIST
  } div_e;

  typedef struct packed {
    logic load;
    logic close_ld;
    logic mul_en;
    mul_e mul_kind;
    logic [1:0] idx;
    logic clr_acc;
    logic big_ld;
    logic norm_step;
    logic sqrt_start;
    logic div_start;
    div_e div_kind;
    logic unit_st;
    logic dist_st;
    logic out_ld;
    res_e res_kind;
    logic state_clr;
  } cmd_t;

  typedef struct packed {
    logic do_newell;
    logic last;
    logic ovf;
    logic degen;
    logic fast;
    logic norm_ok;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== sv/polygon_plane_newell_top.sv =====
// Plane of a polygon by Newell's method. Vertices come in one per request as
// signed Q12.12 x/y/z, the last one marked; one plane result leaves per polygon.
// An ordinary vertex runs its three Newell products through the single shared
// 32x32 multiplier. The last vertex adds the closing edge, then in fast mode
// the six partial products of the first-vertex dot; in accurate mode one-bit
// normalize shifts, a square root and four divisions. A finished result sits
// in the output register while the next polygon's vertices are taken in. Zero
// normal or too many vertices gives an all-zero result with degenerate set.
// depends on ppn_pkg, ppn_ctrl, ppn_dp
module polygon_plane_newell_top #(
  parameter int MAX_VERTICES = ppn_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = ppn_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_x_i,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_y_i,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_z_i,
  input  logic                                last_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_x_o,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_y_o,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_z_o,
  output logic signed [ppn_pkg::DIST_W-1:0]   plane_distance_o,
  output logic                                degenerate_o
);
  import ppn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppn_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .vertex_x_i       (vertex_x_i),
    .vertex_y_i       (vertex_y_i),
    .vertex_z_i       (vertex_z_i),
    .last_vertex_i    (last_vertex_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .normal_x_o       (normal_x_o),
    .normal_y_o       (normal_y_o),
    .normal_z_o       (normal_z_o),
    .plane_distance_o (plane_distance_o),
    .degenerate_o     (degenerate_o)
  );

  // degenerate results carry no plane
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 &&
    normal_z_o == '0 && plane_distance_o == '0)
    else $error("degenerate result with nonzero fields");

  // accurate mode components stay within one unit
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o && !sts.fast |->
    normal_x_o <= 58'sd16384 && normal_x_o >= -58'sd16384 &&
    normal_y_o <= 58'sd16384 && normal_y_o >= -58'sd16384 &&
    normal_z_o <= 58'sd16384 && normal_z_o >= -58'sd16384)
    else $error("unit normal out of range");

  // a new result is only loaded once the previous one is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> !out_valid_o)
    else $error("result loaded over a pending one");

  // vertices are only taken while no plane solve is in flight
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.mul_en && !cmd.div_start && !cmd.sqrt_start)
    else $error("vertex taken during solve");
endmodule

// ===== sv/ppn_div.sv =====
// ppn_div: restoring divider, one quotient bit per cycle
// depends on ppn_pkg
module ppn_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ppn_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [ppn_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [ppn_pkg::DIV_NUM_W-1:0]  quo_o
);
  import ppn_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] num_q, quo_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign qbit = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[DIV_NUM_W-2:0], qbit};
      rem_q <= qbit ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

// ===== sv/ppn_sqrt.sv =====
// ppn_sqrt: floor square root, one result bit per cycle
// depends on ppn_pkg
module ppn_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppn_pkg::SS_W-1:0]    rad_i,
  output logic                        done_o,
  output logic [ppn_pkg::ROOT_W-1:0]  root_o
);
  import ppn_pkg::*;

  localparam int STEPS = SS_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SS_W-1:0]  v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      res_q <= '0;
      bit_q <= SS_W'(1) << (SS_W - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];
endmodule

// ===== sv/ppn_ctrl.sv =====
// ppn_ctrl: sequencer for vertex accumulation and the per-polygon plane solve
// depends on ppn_pkg; drives the datapath through cmd_t, reads sts_t
module ppn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ppn_pkg::sts_t   sts_i,
  output ppn_pkg::cmd_t   cmd_o
);
  import ppn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_VERT, S_NEWELL, S_NDRAIN, S_LASTCHK, S_CLOSE, S_CDRAIN,
    S_DECIDE, S_FAST, S_FDRAIN, S_NORM, S_SQ, S_SQDRAIN, S_SQRT_GO,
    S_SQRT_W, S_DIVN_GO, S_DIVN_W, S_DOT, S_DOTDRAIN, S_DIVD_GO,
    S_DIVD_W, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] k_q, k_d;
  res_e       kind_q, kind_d;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    kind_d = kind_q;
    cmd_o = '0;
    cmd_o.mul_kind = MUL_NEWELL;
    cmd_o.div_kind = DIV_UNIT;
    cmd_o.res_kind = kind_q;
    cmd_o.idx = k_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_VERT;
        end
      end
      S_VERT: begin
        k_d = '0;
        state_d = sts_i.do_newell ? S_NEWELL : S_LASTCHK;
      end
      S_NEWELL, S_CLOSE: begin
        cmd_o.mul_en = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == 3'd2) state_d = (state_q == S_NEWELL) ? S_NDRAIN : S_CDRAIN;
      end
      S_NDRAIN: state_d = S_LASTCHK;
      S_LASTCHK: begin
        k_d = '0;
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (!sts_i.ovf) begin
          cmd_o.close_ld = 1'b1;
          state_d = S_CLOSE;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CDRAIN: state_d = S_DECIDE;
      S_DECIDE: begin
        cmd_o.clr_acc = 1'b1;
        k_d = '0;
        if (sts_i.degen) begin
          kind_d = RES_DEGEN;
          state_d = S_FIN;
        end else if (sts_i.fast) begin
          kind_d = RES_FAST;
          state_d = S_FAST;
        end else begin
          kind_d = RES_ACC;
          cmd_o.big_ld = 1'b1;
          state_d = S_NORM;
        end
      end
      S_FAST: begin
        // even steps take the low half of a sum, odd steps the high half
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_kind = k_q[0] ? MUL_FAST_HI : MUL_FAST_LO;
        cmd_o.idx = k_q[2:1];
        k_d = k_q + 1'b1;
        if (k_q == 3'd5) state_d = S_FDRAIN;
      end
      S_FDRAIN: state_d = S_FIN;
      S_NORM: begin
        if (sts_i.norm_ok) state_d = S_SQ;
        else cmd_o.norm_step = 1'b1;
      end
      S_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_kind = MUL_SQUARE;
        k_d = k_q + 1'b1;
        if (k_q == 3'd2) state_d = S_SQDRAIN;
      end
      S_SQDRAIN: state_d = S_SQRT_GO;
      S_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRT_W;
      end
      S_SQRT_W: begin
        k_d = '0;
        if (sts_i.sqrt_done) state_d = S_DIVN_GO;
      end
      S_DIVN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVN_W;
      end
      S_DIVN_W: begin
        if (sts_i.div_done) begin
          cmd_o.unit_st = 1'b1;
          if (k_q == 3'd2) begin
            k_d = '0;
            state_d = S_DOT;
          end else begin
            k_d = k_q + 1'b1;
            state_d = S_DIVN_GO;
          end
        end
      end
      S_DOT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_kind = MUL_DOT;
        k_d = k_q + 1'b1;
        if (k_q == 3'd2) state_d = S_DOTDRAIN;
      end
      S_DOTDRAIN: state_d = S_DIVD_GO;
      S_DIVD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind = DIV_DIST;
        state_d = S_DIVD_W;
      end
      S_DIVD_W: begin
        cmd_o.div_kind = DIV_DIST;
        if (sts_i.div_done) begin
          cmd_o.dist_st = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to drain before overwriting it
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.state_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= '0;
      kind_q <= RES_DEGEN;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      kind_q <= kind_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule

// ===== sv/ppn_dp.sv =====
// ppn_dp: polygon state, shared 32x32 multiplier, normalizer, root and divider
// depends on ppn_pkg, ppn_sqrt, ppn_div
module ppn_dp #(
  parameter int MAX_VERTICES = ppn_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = ppn_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ppn_pkg::cmd_t                       cmd_i,
  output ppn_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_x_i,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_y_i,
  input  logic signed [ppn_pkg::COORD_W-1:0]  vertex_z_i,
  input  logic                                last_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_x_o,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_y_o,
  output logic signed [ppn_pkg::NORM_W-1:0]   normal_z_o,
  output logic signed [ppn_pkg::DIST_W-1:0]   plane_distance_o,
  output logic                                degenerate_o
);
  import ppn_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic                      fast_q;
  logic signed [COORD_W-1:0] cur [3];
  logic signed [COORD_W-1:0] cur_q [3], first_q [3], prev_q [3], opp_q [3], opc_q [3];
  logic signed [NORM_W-1:0]  ns_q [3];
  logic signed [CSUM_W-1:0]  csum_q [3];
  logic [CNT_W-1:0]          count_q;
  logic                      ovf_q, last_q, do_newell_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      acc_vld_q;
  mul_e                      acc_kind_q;
  logic [1:0]                acc_idx_q;
  logic signed [WACC_W-1:0]  wacc_q;
  logic [SS_W-1:0]           ss_q;
  logic signed [PROD_W-1:0]  dot_q;

  logic [NORM_W-1:0]         mag_q [3];
  logic [NORM_W-1:0]         big_q;
  logic signed [UNIT_W-1:0]  unit_q [3];
  logic signed [DIST_W-1:0]  dist_q;

  logic                      sqrt_done, div_done;
  logic [ROOT_W-1:0]         root;
  logic [DIV_NUM_W-1:0]      div_num, quo;
  logic [DIV_DEN_W-1:0]      div_den;

  logic signed [COORD_W:0]   nd, nsum;
  logic [1:0]                ia, ib;
  logic [PROD_W-1:0]         dot_mag;
  logic signed [UNIT_W-1:0]  uq;
  logic signed [DIST_W-1:0]  sat;
  logic                      wacc_fits;
  logic                      out_vld_q;

  assign cur[0] = COORD_W'($signed(vertex_x_i[COORD_BITS-1:0]));
  assign cur[1] = COORD_W'($signed(vertex_y_i[COORD_BITS-1:0]));
  assign cur[2] = COORD_W'($signed(vertex_z_i[COORD_BITS-1:0]));

  // newell term k pairs component k+1 difference with k+2 sum
  always_comb begin
    unique case (cmd_i.idx)
      2'd0: begin ia = 2'd1; ib = 2'd2; end
      2'd1: begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
    nd = (COORD_W+1)'(opp_q[ia]) - (COORD_W+1)'(opc_q[ia]);
    nsum = (COORD_W+1)'(opp_q[ib]) + (COORD_W+1)'(opc_q[ib]);
    unique case (cmd_i.mul_kind)
      MUL_NEWELL: begin
        mul_a = MUL_W'(nd);
        mul_b = MUL_W'(nsum);
      end
      MUL_FAST_LO: begin
        mul_a = MUL_W'(first_q[cmd_i.idx]);
        mul_b = $signed(MUL_W'(ns_q[cmd_i.idx][28:0]));
      end
      MUL_FAST_HI: begin
        mul_a = MUL_W'(first_q[cmd_i.idx]);
        mul_b = MUL_W'($signed(ns_q[cmd_i.idx][NORM_W-1:29]));
      end
      MUL_SQUARE: begin
        mul_a = $signed(MUL_W'(mag_q[cmd_i.idx][29:0]));
        mul_b = $signed(MUL_W'(mag_q[cmd_i.idx][29:0]));
      end
      default: begin
        mul_a = csum_q[cmd_i.idx];
        mul_b = MUL_W'(unit_q[cmd_i.idx]);
      end
    endcase
  end

  assign dot_mag = dot_q[PROD_W-1] ? PROD_W'(-dot_q) : PROD_W'(dot_q);

  always_comb begin
    if (cmd_i.div_kind == DIV_UNIT) begin
      div_num = DIV_NUM_W'({mag_q[cmd_i.idx][29:0], {FRAC_W{1'b0}}})
              + DIV_NUM_W'(root >> 1);
      div_den = DIV_DEN_W'(root);
    end else begin
      div_num = dot_mag[DIV_NUM_W-1:0] + DIV_NUM_W'({count_q, {(FRAC_W-1){1'b0}}});
      div_den = DIV_DEN_W'({count_q, {FRAC_W{1'b0}}});
    end
  end

  ppn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (ss_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  ppn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign uq = $signed(UNIT_W'(quo[FRAC_W:0]));
  assign wacc_fits = (&wacc_q[WACC_W-1:DIST_W-1]) || !(|wacc_q[WACC_W-1:DIST_W-1]);
  assign sat = wacc_fits ? wacc_q[DIST_W-1:0]
             : (wacc_q[WACC_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= 1'b0;
      count_q <= '0;
      ovf_q <= 1'b0;
      last_q <= 1'b0;
      do_newell_q <= 1'b0;
      acc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_q[i] <= '0;
        prev_q[i] <= '0;
        ns_q[i] <= '0;
        csum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) fast_q <= cfg_wdata_i;
      acc_vld_q <= cmd_i.mul_en;
      if (cmd_i.out_ld) out_vld_q <= 1'b1;
      else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;

      if (cmd_i.state_clr) begin
        count_q <= '0;
        ovf_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          first_q[i] <= '0;
          prev_q[i] <= '0;
          ns_q[i] <= '0;
          csum_q[i] <= '0;
        end
      end else if (cmd_i.load) begin
        last_q <= last_vertex_i;
        if (count_q >= CNT_W'(MAX_VERTICES)) begin
          ovf_q <= 1'b1;
          do_newell_q <= 1'b0;
        end else begin
          do_newell_q <= (count_q != '0);
          count_q <= count_q + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (count_q == '0) first_q[i] <= cur[i];
            prev_q[i] <= cur[i];
            csum_q[i] <= csum_q[i] + CSUM_W'(cur[i]);
          end
        end
      end else if (acc_vld_q && acc_kind_q == MUL_NEWELL) begin
        ns_q[acc_idx_q] <= ns_q[acc_idx_q] + NORM_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a * mul_b);
    acc_kind_q <= cmd_i.mul_kind;
    acc_idx_q <= cmd_i.idx;
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= cur[i];
        opp_q[i] <= prev_q[i];
        opc_q[i] <= cur[i];
      end
    end else if (cmd_i.close_ld) begin
      for (int i = 0; i < 3; i++) begin
        opp_q[i] <= cur_q[i];
        opc_q[i] <= first_q[i];
      end
    end

    if (cmd_i.clr_acc) begin
      wacc_q <= '0;
      ss_q <= '0;
      dot_q <= '0;
    end else if (acc_vld_q) begin
      unique case (acc_kind_q)
        MUL_FAST_LO: wacc_q <= wacc_q + WACC_W'(prod_q);
        MUL_FAST_HI: wacc_q <= wacc_q + (WACC_W'(prod_q) <<< 29);
        MUL_SQUARE:  ss_q <= ss_q + SS_W'(prod_q);
        MUL_DOT:     dot_q <= dot_q + prod_q;
        default:     ;
      endcase
    end

    // any set bit in the or of magnitudes tracks the largest leading one
    if (cmd_i.big_ld) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= ns_q[i][NORM_W-1] ? NORM_W'(-ns_q[i]) : NORM_W'(ns_q[i]);
      end
      big_q <= (ns_q[0][NORM_W-1] ? NORM_W'(-ns_q[0]) : NORM_W'(ns_q[0]))
             | (ns_q[1][NORM_W-1] ? NORM_W'(-ns_q[1]) : NORM_W'(ns_q[1]))
             | (ns_q[2][NORM_W-1] ? NORM_W'(-ns_q[2]) : NORM_W'(ns_q[2]));
    end else if (cmd_i.norm_step) begin
      if (|big_q[NORM_W-1:30]) begin
        big_q <= big_q >> 1;
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      end else begin
        big_q <= big_q << 1;
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
      end
    end

    if (cmd_i.unit_st) unit_q[cmd_i.idx] <= ns_q[cmd_i.idx][NORM_W-1] ? -uq : uq;
    if (cmd_i.dist_st) begin
      dist_q <= dot_q[PROD_W-1] ? -DIST_W'(quo) : DIST_W'(quo);
    end

    if (cmd_i.out_ld) begin
      unique case (cmd_i.res_kind)
        RES_FAST: begin
          normal_x_o <= ns_q[0];
          normal_y_o <= ns_q[1];
          normal_z_o <= ns_q[2];
          plane_distance_o <= sat;
          degenerate_o <= 1'b0;
        end
        RES_ACC: begin
          normal_x_o <= NORM_W'(unit_q[0]);
          normal_y_o <= NORM_W'(unit_q[1]);
          normal_z_o <= NORM_W'(unit_q[2]);
          plane_distance_o <= dist_q;
          degenerate_o <= 1'b0;
        end
        default: begin
          normal_x_o <= '0;
          normal_y_o <= '0;
          normal_z_o <= '0;
          plane_distance_o <= '0;
          degenerate_o <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    sts_o.do_newell = do_newell_q;
    sts_o.last = last_q;
    sts_o.ovf = ovf_q;
    sts_o.degen = ovf_q || (ns_q[0] == '0 && ns_q[1] == '0 && ns_q[2] == '0);
    sts_o.fast = fast_q;
    sts_o.norm_ok = (big_q[NORM_W-1:30] == '0) && big_q[29];
    sts_o.sqrt_done = sqrt_done;
    sts_o.div_done = div_done;
    sts_o.out_busy = out_vld_q;
  end
endmodule
